// ===== rtl/tlba_pkg.sv =====
// Shared types, constants and the helper function of the two-level bitmap block allocator.
`timescale 1ns / 1ps

package tlba_pkg;

  // Default pool geometry.
  localparam int NUM_GROUPS_DEF       = 64;
  localparam int BLOCKS_PER_GROUP_DEF = 64;

  // Fixed field layout of a block address: group in the upper half, block in the lower.
  localparam int GRP_FIELD_W = 6;
  localparam int BLK_FIELD_W = 6;
  localparam int ADDR_W      = GRP_FIELD_W + BLK_FIELD_W;

  // Width of the bit scan used by the lowest-set search.
  localparam int SCAN_W  = 64;
  localparam int SCAN_IW = 6;

  // Largest size class that an allocation accepts.
  localparam logic [1:0] SIZE_MAX_OK = 2'd1;

  // Request commands; every other code is answered with a failure.
  typedef enum logic [1:0] {
    MODE_ALLOC = 2'd0,
    MODE_FREE  = 2'd1
  } mode_e;

  // Decoded operation held for the execute step.
  typedef enum logic [1:0] {
    OP_ALLOC,
    OP_FREE,
    OP_SKIP,
    OP_FAIL
  } op_e;

  // Input item.
  typedef struct packed {
    logic [1:0]        mode;
    logic [1:0]        block_size;
    logic [ADDR_W-1:0] free_address;
  } req_t;

  // Result item.
  typedef struct packed {
    logic              failed;
    logic [ADDR_W-1:0] block_address;
  } rsp_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic commit;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic has_result;
    logic out_free;
  } dp_status_t;

  // Index of the lowest set bit of a word; zero for an empty word.
  function automatic logic [SCAN_IW-1:0] lowest_set(input logic [SCAN_W-1:0] w);
    logic [SCAN_W-1:0]  iso;
    logic [SCAN_IW-1:0] idx;
    iso = w & (~w + SCAN_W'(1));
    idx = '0;
    for (int i = 0; i < SCAN_W; i++) begin
      if (iso[i]) begin
        idx = idx | SCAN_IW'(i);
      end
    end
    return idx;
  endfunction

endpackage

// ===== rtl/tlba_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
`timescale 1ns / 1ps

module tlba_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port; the data holds while no read is issued.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/tlba_datapath.sv =====
// Datapath of the allocator: summary word, leaf memory, search logic and result register.
`timescale 1ns / 1ps

module tlba_datapath import tlba_pkg::*; #(
  parameter int NUM_GROUPS       = NUM_GROUPS_DEF,
  parameter int BLOCKS_PER_GROUP = BLOCKS_PER_GROUP_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  ctrl_cmd_t  cmd_i,
  output dp_status_t status_o,
  input  req_t       in_data_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output rsp_t       out_data_o
);

  localparam int GRP_AW = $clog2(NUM_GROUPS);
  localparam int BLK_AW = $clog2(BLOCKS_PER_GROUP);
  localparam int CMP_W  = GRP_FIELD_W + 1;
  localparam logic [BLOCKS_PER_GROUP-1:0] LEAF_FULL = '1;
  localparam logic [BLOCKS_PER_GROUP-1:0] LEAF_ONE  = BLOCKS_PER_GROUP'(1);

  logic [NUM_GROUPS-1:0]       summary_q, summary_d;
  logic [NUM_GROUPS-1:0]       touched_q, touched_d;
  op_e                         op_q, op_d;
  logic [GRP_AW-1:0]           grp_q;
  logic [BLK_AW-1:0]           blk_q;
  logic                        out_valid_q, out_valid_d;
  rsp_t                        out_data_q;

  logic [GRP_FIELD_W-1:0]      in_grp;
  logic [BLK_FIELD_W-1:0]      in_blk;
  logic                        in_range;
  logic [SCAN_IW-1:0]          alloc_grp_idx;
  logic [GRP_AW-1:0]           sel_grp;

  logic [BLOCKS_PER_GROUP-1:0] rdata;
  logic [BLOCKS_PER_GROUP-1:0] leaf;
  logic [SCAN_IW-1:0]          alloc_blk_idx;
  logic [BLK_AW-1:0]           tgt_blk;
  logic [BLOCKS_PER_GROUP-1:0] bit_mask;
  logic [BLOCKS_PER_GROUP-1:0] new_leaf;
  logic                        leaf_we;
  logic                        has_result;
  logic                        out_free;
  rsp_t                        result;

  // Lookup: pick the lowest group with a free block, or the group named by a free request.
  assign in_grp        = in_data_i.free_address[ADDR_W-1:BLK_FIELD_W];
  assign in_blk        = in_data_i.free_address[BLK_FIELD_W-1:0];
  assign in_range      = (CMP_W'(in_grp) < CMP_W'(NUM_GROUPS)) &&
                         (CMP_W'(in_blk) < CMP_W'(BLOCKS_PER_GROUP));
  assign alloc_grp_idx = lowest_set(SCAN_W'(summary_q));
  assign sel_grp       = (in_data_i.mode == MODE_ALLOC) ? alloc_grp_idx[GRP_AW-1:0]
                                                        : in_grp[GRP_AW-1:0];

  // Decode the request into the operation carried to the execute step.
  always_comb begin
    case (in_data_i.mode)
      MODE_ALLOC: begin
        if (summary_q == '0 || in_data_i.block_size > SIZE_MAX_OK) begin
          op_d = OP_FAIL;
        end else begin
          op_d = OP_ALLOC;
        end
      end
      MODE_FREE: begin
        op_d = in_range ? OP_FREE : OP_SKIP;
      end
      default: begin
        op_d = OP_FAIL;
      end
    endcase
  end

  // Leaf words, one per group.
  tlba_ram #(
    .WIDTH (BLOCKS_PER_GROUP),
    .DEPTH (NUM_GROUPS),
    .AW    (GRP_AW)
  ) u_leaf_ram (
    .clk_i   (clk_i),
    .we_i    (leaf_we),
    .waddr_i (grp_q),
    .wdata_i (new_leaf),
    .re_i    (cmd_i.load),
    .raddr_i (sel_grp),
    .rdata_o (rdata)
  );

  // Execute: a leaf never written since reset reads as fully free.
  assign leaf          = touched_q[grp_q] ? rdata : LEAF_FULL;
  assign alloc_blk_idx = lowest_set(SCAN_W'(leaf));
  assign tgt_blk       = (op_q == OP_ALLOC) ? alloc_blk_idx[BLK_AW-1:0] : blk_q;
  assign bit_mask      = LEAF_ONE << tgt_blk;
  assign new_leaf      = (op_q == OP_ALLOC) ? (leaf & ~bit_mask) : (leaf | bit_mask);
  assign leaf_we       = cmd_i.commit && (op_q == OP_ALLOC || op_q == OP_FREE);

  // Summary and written-mark updates.
  always_comb begin
    summary_d = summary_q;
    touched_d = touched_q;
    if (leaf_we) begin
      touched_d[grp_q] = 1'b1;
      if (op_q == OP_FREE) begin
        summary_d[grp_q] = 1'b1;
      end else if (new_leaf == '0) begin
        summary_d[grp_q] = 1'b0;
      end
    end
  end

  // Result formation.
  assign has_result = (op_q == OP_ALLOC) || (op_q == OP_FAIL);
  always_comb begin
    result.failed        = (op_q == OP_FAIL);
    result.block_address = '0;
    if (op_q == OP_ALLOC) begin
      result.block_address = {GRP_FIELD_W'(grp_q), BLK_FIELD_W'(tgt_blk)};
    end
  end

  // Output register: empties when the receiver takes the item.
  assign out_free = !out_valid_q || !out_stall_i;
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.commit && has_result) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      summary_q   <= '1;
      touched_q   <= '0;
      op_q        <= OP_SKIP;
      out_valid_q <= 1'b0;
    end else begin
      summary_q   <= summary_d;
      touched_q   <= touched_d;
      out_valid_q <= out_valid_d;
      if (cmd_i.load) begin
        op_q <= op_d;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      grp_q <= sel_grp;
      blk_q <= in_blk[BLK_AW-1:0];
    end
    if (cmd_i.commit && has_result) begin
      out_data_q <= result;
    end
  end

  assign status_o.has_result = has_result;
  assign status_o.out_free   = out_free;
  assign out_valid_o         = out_valid_q;
  assign out_data_o          = out_data_q;

endmodule

// ===== rtl/tlba_ctrl.sv =====
// Controller of the allocator: sequences lookup and execute for one item at a time.
`timescale 1ns / 1ps

module tlba_ctrl import tlba_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  dp_status_t status_i,
  output ctrl_cmd_t  cmd_o
);

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_e;

  state_e state_q;
  logic   stall_q;

  // An item is taken in idle; it commits once its result has room.
  assign cmd_o.load   = in_valid_i && (state_q == ST_IDLE);
  assign cmd_o.commit = (state_q == ST_EXEC) && (!status_i.has_result || status_i.out_free);

  // State and the registered stall output.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      stall_q <= 1'b0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (cmd_o.load) begin
            state_q <= ST_EXEC;
            stall_q <= 1'b1;
          end
        end
        ST_EXEC: begin
          if (cmd_o.commit) begin
            state_q <= ST_IDLE;
            stall_q <= 1'b0;
          end
        end
        default: begin
          state_q <= ST_IDLE;
          stall_q <= 1'b0;
        end
      endcase
    end
  end

  assign in_stall_o = stall_q;

endmodule

// ===== rtl/two_level_bitmap_block_allocator.sv =====
// Top level of the two-level bitmap block allocator.
//
// The block hands out single blocks from NUM_GROUPS groups of BLOCKS_PER_GROUP
// blocks. An input item either allocates (the lowest free block of the lowest
// group with room), frees a block, or is an unsupported command. Allocations and
// unsupported commands give one result item; frees give none.
// Both channels use valid and stall; an item moves when valid is high and stall
// is low. Each item has a lookup step, which searches the summary word and reads
// the leaf word from memory, and an execute step, which updates it and writes it
// back; a new item is taken only once the last has committed. A commit with a
// result writes it into the output register. If that register still holds an
// untaken result, the next item that gives a result waits in its execute step and
// the input stays stalled. After reset every block is free; no clearing pass is
// needed, since a per-group mark makes an unwritten leaf word read as all free.
`timescale 1ns / 1ps

module two_level_bitmap_block_allocator import tlba_pkg::*; #(
  parameter int NUM_GROUPS       = NUM_GROUPS_DEF,
  parameter int BLOCKS_PER_GROUP = BLOCKS_PER_GROUP_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  req_t in_data_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output rsp_t out_data_o
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  // Sequencer.
  tlba_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Bitmaps, search and result register.
  tlba_datapath #(
    .NUM_GROUPS       (NUM_GROUPS),
    .BLOCKS_PER_GROUP (BLOCKS_PER_GROUP)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // An accepted item keeps the input stalled in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input not stalled after an item was taken");

  // A new result follows a busy cycle of the block.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared without an item in work");

  // A free request produces no result item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && in_data_i.mode == MODE_FREE |-> ##2 !$rose(out_valid_o))
    else $error("free request produced a result");

endmodule

// ===== test/tb_two_level_bitmap_block_allocator.sv =====
// Self-checking testbench for the two-level bitmap block allocator.
`timescale 1ns / 1ps

module tb_two_level_bitmap_block_allocator;
  import tlba_pkg::*;

  // Pool geometry of the instance under test.
  localparam int NUM_GROUPS       = NUM_GROUPS_DEF;
  localparam int BLOCKS_PER_GROUP = BLOCKS_PER_GROUP_DEF;
  localparam int POOL_BLOCKS      = NUM_GROUPS * BLOCKS_PER_GROUP;

  // Command codes that the block answers with a failure, and the top size code.
  localparam logic [1:0] MODE_BAD_LO = 2'd2;
  localparam logic [1:0] MODE_BAD_HI = 2'd3;
  localparam logic [1:0] SIZE_TOP    = 2'd3;

  localparam int IDLE_PCT      = 36;
  localparam int MAX_REPORTS   = 10;
  localparam int HOLD_CYCLES   = 400;
  localparam int DRAIN_CYCLES  = 20;
  localparam int FILL_GROUPS   = 3;

  logic clk_i       = 1'b0;
  logic rst_ni      = 1'b0;
  logic in_valid_i  = 1'b0;
  logic in_stall_o;
  req_t in_data_i   = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  rsp_t out_data_o;

  two_level_bitmap_block_allocator #(
    .NUM_GROUPS      (NUM_GROUPS),
    .BLOCKS_PER_GROUP(BLOCKS_PER_GROUP)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  // Image of the pool: one summary bit per group and one free bit per block.
  logic [63:0]       group_has_room;
  logic [63:0]       leaf_free [64];
  int                pool_free;
  logic [ADDR_W-1:0] allocated_blocks [$];
  rsp_t              pending_answers [$];

  // Shared controls and statistics.
  bit idle_on      = 1'b1;
  int hold_request = 0;
  int hold_left    = 0;
  int bad_count    = 0;
  int checked      = 0;
  int n_alloc_ok   = 0;
  int n_failed     = 0;
  int n_frees      = 0;

  // Clock with a 2 ns period.
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Index of the lowest set bit; zero for an empty word.
  function automatic int first_one(input logic [63:0] w);
    for (int i = 0; i < 64; i++) begin
      if (w[i]) begin
        return i;
      end
    end
    return 0;
  endfunction

  function automatic void reset_pool_image();
    group_has_room = '0;
    for (int g = 0; g < 64; g++) begin
      leaf_free[g] = '0;
      if (g < NUM_GROUPS) begin
        group_has_room[g] = 1'b1;
        for (int b = 0; b < BLOCKS_PER_GROUP; b++) begin
          leaf_free[g][b] = 1'b1;
        end
      end
    end
    pool_free = POOL_BLOCKS;
    allocated_blocks.delete();
  endfunction

  // Applies one accepted item to the pool image and queues the answer it causes.
  function automatic void update_pool_image(input req_t r);
    rsp_t ans;
    int   g;
    int   b;
    int   hits[$];
    ans = '0;
    case (r.mode)
      MODE_ALLOC: begin
        if (group_has_room == '0 || r.block_size > SIZE_MAX_OK) begin
          ans.failed = 1'b1;
          n_failed++;
        end else begin
          g = first_one(group_has_room);
          b = first_one(leaf_free[g]);
          leaf_free[g][b] = 1'b0;
          if (leaf_free[g] == '0) begin
            group_has_room[g] = 1'b0;
          end
          ans.block_address = ADDR_W'((g << BLK_FIELD_W) | b);
          allocated_blocks.push_back(ans.block_address);
          pool_free--;
          n_alloc_ok++;
        end
        pending_answers.push_back(ans);
      end
      MODE_FREE: begin
        g = int'(r.free_address[ADDR_W-1:BLK_FIELD_W]);
        b = int'(r.free_address[BLK_FIELD_W-1:0]);
        n_frees++;
        // Out-of-range frees are ignored; a free of a free block only sets the summary.
        if (g < NUM_GROUPS && b < BLOCKS_PER_GROUP) begin
          if (!leaf_free[g][b]) begin
            hits = allocated_blocks.find_first_index(x) with (x == r.free_address);
            if (hits.size() > 0) begin
              allocated_blocks.delete(hits[0]);
            end
            pool_free++;
          end
          leaf_free[g][b]   = 1'b1;
          group_has_room[g] = 1'b1;
        end
      end
      default: begin
        ans.failed = 1'b1;
        n_failed++;
        pending_answers.push_back(ans);
      end
    endcase
  endfunction

  function automatic req_t mk_req(input logic [1:0] mode, input logic [1:0] size,
                                  input logic [ADDR_W-1:0] addr);
    req_t r;
    r.mode         = mode;
    r.block_size   = size;
    r.free_address = addr;
    return r;
  endfunction

  // Random item: mostly good allocations and frees of held blocks, some noise.
  function automatic req_t rand_req();
    int   pick;
    req_t r;
    pick = $urandom_range(0, 99);
    r = mk_req(MODE_ALLOC, 2'($urandom_range(0, SIZE_MAX_OK)), ADDR_W'($urandom));
    if (pick >= 45 && pick < 80 && allocated_blocks.size() > 0) begin
      r.mode         = MODE_FREE;
      r.free_address = allocated_blocks[$urandom_range(0, allocated_blocks.size() - 1)];
    end else if (pick >= 45 && pick < 88) begin
      r.mode = MODE_FREE;
    end else if (pick >= 88 && pick < 94) begin
      r.block_size = 2'($urandom_range(SIZE_MAX_OK + 1, SIZE_TOP));
    end else if (pick >= 94) begin
      r.mode       = 2'($urandom_range(MODE_BAD_LO, MODE_BAD_HI));
      r.block_size = 2'($urandom);
    end
    return r;
  endfunction

  // Offers one item, with random gaps before it, and waits until it is taken.
  task automatic send_req(input req_t r);
    while (idle_on && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= r;
    @(posedge clk_i);
    while (in_stall_o) begin
      @(posedge clk_i);
    end
    update_pool_image(r);
  endtask

  // Receiver: random stalls, or a long hold-off when one is requested.
  always @(posedge clk_i) begin
    if (hold_request > 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left--;
    end else begin
      out_stall_i <= idle_on && ($urandom_range(0, 99) < IDLE_PCT);
    end
  end

  // Compares each taken result with the oldest answer still waiting.
  always @(posedge clk_i) begin
    rsp_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_answers.size() == 0) begin
        bad_count++;
        if (bad_count <= MAX_REPORTS) begin
          $display("ERROR: unexpected result failed=%0b address=%0d",
                   out_data_o.failed, out_data_o.block_address);
        end
      end else begin
        want = pending_answers.pop_front();
        checked++;
        if (out_data_o.failed !== want.failed ||
            out_data_o.block_address !== want.block_address) begin
          bad_count++;
          if (bad_count <= MAX_REPORTS) begin
            $display("ERROR: result %0d: expected failed=%0b address=%0d,",
                     checked, want.failed, want.block_address);
            $display("       got failed=%0b address=%0d",
                     out_data_o.failed, out_data_o.block_address);
          end
        end
      end
    end
  end

  // Extremes of every field, every command and the special cases from reset.
  task automatic test_directed();
    send_req(mk_req(MODE_ALLOC, 2'd0, '0));
    send_req(mk_req(MODE_ALLOC, SIZE_MAX_OK, '1));
    send_req(mk_req(MODE_ALLOC, 2'd2, '0));
    send_req(mk_req(MODE_ALLOC, SIZE_TOP, '1));
    send_req(mk_req(MODE_BAD_LO, 2'd0, '0));
    send_req(mk_req(MODE_BAD_HI, SIZE_TOP, '1));
    send_req(mk_req(MODE_BAD_LO, SIZE_TOP, 12'hA5A));
    // Free and reuse of the lowest block.
    send_req(mk_req(MODE_FREE, SIZE_TOP, '0));
    send_req(mk_req(MODE_ALLOC, 2'd0, 12'h5A5));
    // Frees at both ends of the pool of blocks that are already free, and a held block freed twice.
    send_req(mk_req(MODE_FREE, 2'd0, '1));
    send_req(mk_req(MODE_FREE, 2'd2, 12'hFC0));
    send_req(mk_req(MODE_FREE, SIZE_MAX_OK, 12'd1));
    send_req(mk_req(MODE_FREE, SIZE_MAX_OK, 12'd1));
    send_req(mk_req(MODE_ALLOC, SIZE_MAX_OK, '0));
    send_req(mk_req(MODE_ALLOC, 2'd0, '1));
    send_req(mk_req(MODE_ALLOC, SIZE_MAX_OK, '0));
  endtask

  // Fills the lowest groups completely, then frees a block of a full group and reuses it.
  task automatic test_fill_groups();
    while (pool_free > POOL_BLOCKS - FILL_GROUPS * BLOCKS_PER_GROUP) begin
      send_req(mk_req(MODE_ALLOC, 2'($urandom_range(0, SIZE_MAX_OK)), ADDR_W'($urandom)));
    end
    send_req(mk_req(MODE_FREE, 2'd0, '1));
    send_req(mk_req(MODE_FREE, 2'd0, 12'd64));
    send_req(mk_req(MODE_ALLOC, 2'd0, '0));
    send_req(mk_req(MODE_ALLOC, 2'd0, '0));
    send_req(mk_req(MODE_ALLOC, SIZE_MAX_OK, '0));
    send_req(mk_req(MODE_ALLOC, SIZE_TOP, '0));
  endtask

  // Random traffic with idling on both sides.
  task automatic test_random(input int count);
    for (int i = 0; i < count; i++) begin
      send_req(rand_req());
    end
  endtask

  // Random traffic with no idling at all.
  task automatic test_streaming(input int count);
    idle_on = 1'b0;
    test_random(count);
    idle_on = 1'b1;
  endtask

  // The receiver holds off while items keep coming, so the input stalls.
  task automatic test_backpressure();
    hold_request = HOLD_CYCLES;
    for (int i = 0; i < 60; i++) begin
      send_req(mk_req(2'($urandom_range(0, 3) == 0 ? MODE_BAD_LO : MODE_ALLOC),
                      2'($urandom_range(0, SIZE_TOP)), ADDR_W'($urandom)));
    end
  endtask

  // Lets the block finish everything it holds.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_answers.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  initial begin
    reset_pool_image();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_fill_groups();
    test_random(600);
    test_backpressure();
    test_streaming(300);
    test_random(580);
    drain();

    if (pending_answers.size() != 0) begin
      bad_count++;
      $display("ERROR: %0d expected results never arrived", pending_answers.size());
    end
    $display("Run covered %0d good allocations, %0d failures and %0d frees;",
             n_alloc_ok, n_failed, n_frees);
    $display("%0d results checked, whole groups filled and reused, a long receiver hold-off",
             checked);
    $display("and a stretch with no idling on either side.");
    if (bad_count == 0) begin
      $display("** two_level_bitmap_block_allocator: PASSED **");
    end else begin
      $display("%0d mismatches in total", bad_count);
      $display("** two_level_bitmap_block_allocator: FAILED **");
    end
    $finish;
  end

  // Watchdog for a run that hangs.
  initial begin
    #2000000;
    $display("ERROR: timeout");
    $display("** two_level_bitmap_block_allocator: FAILED **");
    $finish;
  end

endmodule
